### rtl/core/pps_pkg.sv
// Shared types, constants and reset values for the position PID step block.
package pps_pkg;

  // Default fixed-point layout.
  localparam int POS_FRAC_BITS_DEF  = 16;
  localparam int GAIN_FRAC_BITS_DEF = 12;
  localparam int INTEGRAL_WIDTH_DEF = 40;

  // Fixed field and datapath widths.
  localparam int POS_W       = 32;
  localparam int DERIV_W     = 33;
  localparam int GAIN_W      = 16;
  localparam int LIMIT_W     = 31;
  localparam int DLIM_W      = 8;
  localparam int DRIVE_W     = 12;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  // Shared multiplier: signed operand A times unsigned gain-format operand B.
  localparam int OPA_W = 33;
  // Wide operands are split at this bit into a low and a high pass.
  localparam int LO_W  = 24;
  localparam int ACC_W = 64;

  // The integral term is held within plus or minus 2^61 before summing.
  localparam logic signed [ACC_W-1:0] TERM_CLAMP = 64'sh2000_0000_0000_0000;

  // Register reset values.
  localparam logic signed [POS_W-1:0] RST_TARGET  = 32'sd0;
  localparam logic [GAIN_W-1:0]       RST_KP      = 16'd8192;
  localparam logic [GAIN_W-1:0]       RST_KI      = 16'd164;
  localparam logic [GAIN_W-1:0]       RST_KD      = 16'd0;
  localparam logic [LIMIT_W-1:0]      RST_ILIM    = 31'd3276800;
  localparam logic [DLIM_W-1:0]       RST_DLIM    = 8'd127;
  localparam logic [LIMIT_W-1:0]      RST_TOL     = 31'd1966;
  localparam logic [GAIN_W-1:0]       RST_OSCALE  = 16'd4096;

  typedef enum logic [CFG_AW-1:0] {
    REG_TARGET     = 3'd0,
    REG_KP         = 3'd1,
    REG_KI         = 3'd2,
    REG_KD         = 3'd3,
    REG_ILIM       = 3'd4,
    REG_DLIM       = 3'd5,
    REG_TOL        = 3'd6,
    REG_OSCALE     = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_INTG,
    ST_KI_LO,
    ST_KI_HI,
    ST_KP,
    ST_KD,
    ST_SUM,
    ST_LIMIT,
    ST_SC_LO,
    ST_SC_HI,
    ST_SC_SUM,
    ST_OUT
  } state_t;

  // Control that travels with one product through the multiplier register.
  typedef struct packed {
    logic add;    // add the product into the accumulator
    logic hi;     // product belongs to the high split, shift it up by LO_W
    logic clamp;  // clamp the accumulator to the integral term range first
  } mac_ctl_t;

endpackage

### rtl/core/pps_mac.sv
// Shared multiply-accumulate unit: registered product, then a 64-bit accumulate.
module pps_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pps_pkg::mac_ctl_t                  ctl,
  input  logic                               clear,
  input  logic signed [pps_pkg::OPA_W-1:0]   op_a,
  input  logic        [pps_pkg::GAIN_W-1:0]  op_b,
  output logic signed [pps_pkg::ACC_W-1:0]   acc
);
  import pps_pkg::*;

  localparam int PROD_W = OPA_W + GAIN_W + 1;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  mac_ctl_t                 pctl_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W-1:0]  addend;
  logic        [ACC_W-1:0]  prod_ext;

  always_comb begin
    prod_nxt = op_a * $signed({1'b0, op_b});
  end

  always_comb begin
    prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    if (pctl_r.hi) begin
      addend = $signed({prod_ext[ACC_W-1-LO_W:0], {LO_W{1'b0}}});
    end else begin
      addend = $signed(prod_ext);
    end
    base = acc_r;
    if (pctl_r.clamp) begin
      if (acc_r > TERM_CLAMP) begin
        base = TERM_CLAMP;
      end else if (acc_r < -TERM_CLAMP) begin
        base = -TERM_CLAMP;
      end
    end
    acc_nxt = acc_r;
    if (clear) begin
      acc_nxt = '0;
    end else if (pctl_r.add) begin
      acc_nxt = base + addend;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (!rst_n) begin
      pctl_r <= '0;
      acc_r  <= '0;
    end else begin
      pctl_r <= ctl;
      acc_r  <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

### rtl/core/pid_position_step_top.sv
// Top level of the position PID step block: registers, sequencer and datapath.
//
// Usage: each input beat is one control tick. in_tdata carries the encoder
// position and in_tuser the restart flag, which clears the integral and the
// last error before the tick is computed. Each tick yields exactly one output
// beat with the scaled, clamped drive command and the done flag.
//
// Timing: in_tready is high only while the block is idle. After a beat is
// accepted, the result is loaded into the output register at the end of
// the sequence and in_tready rises again in the same cycle, so a new tick
// is taken only once the last result has been loaded. The pace is set by
// the single shared multiplier, which runs six passes per tick (two for
// the integral term, one each for the proportional and derivative terms,
// two for the output scaling), each product registered, then accumulated.
//
// Reset (rst_n low at a clock edge) restores all gain and limit registers to
// their defaults, clears the integral and the last error, and empties the
// output register. If the receiver stalls, the result waits in the output
// register; a new tick may still be accepted and computed meanwhile, and the
// block only holds its next result back until the waiting one is taken.
// Configuration writes take effect at once and should be made while idle.
module pid_position_step_top #(
  parameter int POS_FRAC_BITS  = pps_pkg::POS_FRAC_BITS_DEF,
  parameter int GAIN_FRAC_BITS = pps_pkg::GAIN_FRAC_BITS_DEF,
  parameter int INTEGRAL_WIDTH = pps_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pps_pkg::POS_W-1:0]           in_tdata,   // [31:0] position
  input  logic                                in_tuser,   // [0] restart
  // Result channel.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pps_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [11:0] drive, [12] done_res
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [pps_pkg::CFG_AW-1:0]          cfg_addr,
  input  logic [pps_pkg::CFG_DW-1:0]          cfg_wdata
);
  import pps_pkg::*;

  localparam int IW         = INTEGRAL_WIDTH;
  localparam int PROD_FRAC  = POS_FRAC_BITS + GAIN_FRAC_BITS;
  localparam int SC_SHIFT   = PROD_FRAC + GAIN_FRAC_BITS;
  // The clamped sum magnitude is at most drive_limit scaled by PROD_FRAC.
  localparam int MAG_W      = (PROD_FRAC + DLIM_W > LO_W) ? PROD_FRAC + DLIM_W : LO_W + 1;
  localparam int IHI_W      = IW - LO_W;
  localparam int MHI_W      = MAG_W - LO_W;

  localparam logic signed [POS_W+1:0] E_HI = 34'sd2147483647;
  localparam logic signed [POS_W+1:0] E_LO = -34'sd2147483648;
  localparam logic [DRIVE_W-1:0]      DRIVE_MAX = 12'h7FF;
  localparam logic [DRIVE_W-1:0]      DRIVE_MIN = 12'h800;
  localparam logic [ACC_W-1:0]        MAG_POS_MAX = 64'd2047;
  localparam logic [ACC_W-1:0]        MAG_NEG_MAX = 64'd2048;

  // Configuration registers.
  logic signed [POS_W-1:0]   target_r;
  logic [GAIN_W-1:0]         kp_r;
  logic [GAIN_W-1:0]         ki_r;
  logic [GAIN_W-1:0]         kd_r;
  logic [LIMIT_W-1:0]        ilim_r;
  logic [DLIM_W-1:0]         dlim_r;
  logic [LIMIT_W-1:0]        tol_r;
  logic [GAIN_W-1:0]         oscale_r;

  // Sequencer and datapath state.
  state_t                    state_r, state_nxt;
  logic signed [POS_W-1:0]   pos_r, pos_nxt;
  logic signed [POS_W-1:0]   e_r, e_nxt;
  logic signed [IW-1:0]      integral_r, integral_nxt;
  logic signed [POS_W-1:0]   prev_r, prev_nxt;
  logic signed [DERIV_W-1:0] deriv_r, deriv_nxt;
  logic                      done_r, done_nxt;
  logic [MAG_W-1:0]          mag_r, mag_nxt;
  logic                      neg_r, neg_nxt;
  logic                      out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]    out_tdata_r, out_tdata_nxt;

  // Combinational helpers.
  logic                      in_accept;
  logic                      out_free;
  logic signed [POS_W+1:0]   e_wide;
  logic signed [POS_W-1:0]   e_sat;
  logic [POS_W-1:0]          abs_e;
  logic signed [IW:0]        int_sum;
  logic signed [IW-1:0]      int_sat;
  logic signed [DERIV_W-1:0] deriv_calc;
  logic signed [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]          lim_u;
  logic [ACC_W-1:0]          abs_acc;
  logic [ACC_W-1:0]          m64;
  logic [DRIVE_W-1:0]        drive_val;

  // Multiplier controls.
  mac_ctl_t                  mac_ctl;
  logic                      mac_clear;
  logic signed [OPA_W-1:0]   op_a;
  logic [GAIN_W-1:0]         op_b;

  assign in_accept  = in_tvalid && in_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  pps_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .clear (mac_clear),
    .op_a  (op_a),
    .op_b  (op_b),
    .acc   (acc)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_accept) state_nxt = ST_ERR;
      ST_ERR:    state_nxt = ST_INTG;
      ST_INTG:   state_nxt = ST_KI_LO;
      ST_KI_LO:  state_nxt = ST_KI_HI;
      ST_KI_HI:  state_nxt = ST_KP;
      ST_KP:     state_nxt = ST_KD;
      ST_KD:     state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_LIMIT;
      ST_LIMIT:  state_nxt = ST_SC_LO;
      ST_SC_LO:  state_nxt = ST_SC_HI;
      ST_SC_HI:  state_nxt = ST_SC_SUM;
      ST_SC_SUM: state_nxt = ST_OUT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Multiplier operand selection for each pass.
  always_comb begin
    mac_ctl   = '0;
    mac_clear = 1'b0;
    op_a      = '0;
    op_b      = '0;
    case (state_r)
      ST_INTG: begin
        mac_clear = 1'b1;
      end
      ST_KI_LO: begin
        mac_ctl.add = 1'b1;
        op_a = $signed({{(OPA_W-LO_W){1'b0}}, integral_r[LO_W-1:0]});
        op_b = ki_r;
      end
      ST_KI_HI: begin
        mac_ctl.add = 1'b1;
        mac_ctl.hi  = 1'b1;
        op_a = $signed({{(OPA_W-IHI_W){integral_r[IW-1]}}, integral_r[IW-1:LO_W]});
        op_b = ki_r;
      end
      ST_KP: begin
        mac_ctl.add   = 1'b1;
        mac_ctl.clamp = 1'b1;
        op_a = $signed({e_r[POS_W-1], e_r});
        op_b = kp_r;
      end
      ST_KD: begin
        mac_ctl.add = 1'b1;
        op_a = deriv_r;
        op_b = kd_r;
      end
      ST_LIMIT: begin
        mac_clear = 1'b1;
      end
      ST_SC_LO: begin
        mac_ctl.add = 1'b1;
        op_a = $signed({{(OPA_W-LO_W){1'b0}}, mag_r[LO_W-1:0]});
        op_b = oscale_r;
      end
      ST_SC_HI: begin
        mac_ctl.add = 1'b1;
        mac_ctl.hi  = 1'b1;
        op_a = $signed({{(OPA_W-MHI_W){1'b0}}, mag_r[MAG_W-1:LO_W]});
        op_b = oscale_r;
      end
      default: ;
    endcase
  end

  // Arithmetic on the registered operands.
  always_comb begin
    e_wide = -$signed({{2{pos_r[POS_W-1]}}, pos_r})
             - $signed({{2{target_r[POS_W-1]}}, target_r});
    if (e_wide > E_HI) begin
      e_sat = E_HI[POS_W-1:0];
    end else if (e_wide < E_LO) begin
      e_sat = E_LO[POS_W-1:0];
    end else begin
      e_sat = e_wide[POS_W-1:0];
    end

    abs_e = e_r[POS_W-1] ? POS_W'(-e_r) : POS_W'(e_r);

    int_sum = $signed({integral_r[IW-1], integral_r})
              + $signed({{(IW+1-POS_W){e_r[POS_W-1]}}, e_r});
    if (int_sum[IW] != int_sum[IW-1]) begin
      int_sat = int_sum[IW] ? $signed({1'b1, {(IW-1){1'b0}}})
                            : $signed({1'b0, {(IW-1){1'b1}}});
    end else begin
      int_sat = int_sum[IW-1:0];
    end

    deriv_calc = $signed({e_r[POS_W-1], e_r}) - $signed({prev_r[POS_W-1], prev_r});

    lim_u   = {{(ACC_W-DLIM_W){1'b0}}, dlim_r} << PROD_FRAC;
    abs_acc = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

    // In the scaling passes the accumulator holds a nonnegative product.
    m64 = ACC_W'(acc) >> SC_SHIFT;
    if (neg_r) begin
      drive_val = (m64 > MAG_NEG_MAX) ? DRIVE_MIN : DRIVE_W'(12'd0 - m64[DRIVE_W-1:0]);
    end else begin
      drive_val = (m64 > MAG_POS_MAX) ? DRIVE_MAX : m64[DRIVE_W-1:0];
    end
  end

  // Datapath next values.
  always_comb begin
    pos_nxt        = pos_r;
    e_nxt          = e_r;
    integral_nxt   = integral_r;
    prev_nxt       = prev_r;
    deriv_nxt      = deriv_r;
    done_nxt       = done_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          pos_nxt = in_tdata;
          if (in_tuser) begin
            integral_nxt = '0;
            prev_nxt     = '0;
          end
        end
      end
      ST_ERR: begin
        e_nxt = e_sat;
      end
      ST_INTG: begin
        // Integrate only inside the error window; a zero ki holds it at zero.
        if (ki_r == '0) begin
          integral_nxt = '0;
        end else if (abs_e < {1'b0, ilim_r}) begin
          integral_nxt = int_sat;
        end else begin
          integral_nxt = '0;
        end
        deriv_nxt = deriv_calc;
        prev_nxt  = e_r;
        done_nxt  = (abs_e <= {1'b0, tol_r});
      end
      ST_LIMIT: begin
        if (acc > $signed(lim_u)) begin
          mag_nxt = lim_u[MAG_W-1:0];
          neg_nxt = 1'b0;
        end else if (acc < -$signed(lim_u)) begin
          mag_nxt = lim_u[MAG_W-1:0];
          neg_nxt = 1'b1;
        end else begin
          mag_nxt = abs_acc[MAG_W-1:0];
          neg_nxt = acc[ACC_W-1];
        end
      end
      default: ;
    endcase

    if (state_r == ST_OUT && out_free) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {{(OUT_TDATA_W-DRIVE_W-1){1'b0}}, done_r, drive_val};
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    e_r         <= e_nxt;
    deriv_r     <= deriv_nxt;
    done_r      <= done_nxt;
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    out_tdata_r <= out_tdata_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      integral_r   <= '0;
      prev_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      integral_r   <= integral_nxt;
      prev_r       <= prev_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Configuration registers; every index of the port maps to a register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= RST_TARGET;
      kp_r     <= RST_KP;
      ki_r     <= RST_KI;
      kd_r     <= RST_KD;
      ilim_r   <= RST_ILIM;
      dlim_r   <= RST_DLIM;
      tol_r    <= RST_TOL;
      oscale_r <= RST_OSCALE;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        REG_TARGET: target_r <= $signed(cfg_wdata[POS_W-1:0]);
        REG_KP:     kp_r     <= cfg_wdata[GAIN_W-1:0];
        REG_KI:     ki_r     <= cfg_wdata[GAIN_W-1:0];
        REG_KD:     kd_r     <= cfg_wdata[GAIN_W-1:0];
        REG_ILIM:   ilim_r   <= cfg_wdata[LIMIT_W-1:0];
        REG_DLIM:   dlim_r   <= cfg_wdata[DLIM_W-1:0];
        REG_TOL:    tol_r    <= cfg_wdata[LIMIT_W-1:0];
        REG_OSCALE: oscale_r <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A restart beat leaves no integral and no last error behind.
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=> (integral_r == '0 && prev_r == '0))
    else $error("restart did not clear the integral and last error");

  // A zero integral gain holds the integral at zero after its update.
  a_ki_zero_integral: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INTG && ki_r == '0) |=> (integral_r == '0))
    else $error("integral not zero with zero ki");

  // A zero drive limit leaves nothing to scale.
  a_zero_limit_mag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIMIT && dlim_r == '0) |=> (mag_r == '0))
    else $error("clamped magnitude nonzero with zero drive limit");
`endif

endmodule
